### hdl/ssm_diagonal_recurrence_step_top_assert.svh
// Assertion macros used by the checker file.
`ifndef SSM_DIAGONAL_RECURRENCE_STEP_TOP_ASSERT_SVH
`define SSM_DIAGONAL_RECURRENCE_STEP_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SSM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define SSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ssmdr_pkg.sv
`timescale 1ns / 1ps

package ssmdr_pkg;

    // Operation codes of an input beat.
    localparam logic [2:0] OP_LOAD_IN_WEIGHT  = 3'd0;
    localparam logic [2:0] OP_LOAD_DECAY      = 3'd1;
    localparam logic [2:0] OP_LOAD_OUT_WEIGHT = 3'd2;
    localparam logic [2:0] OP_LOAD_STATE      = 3'd3;
    localparam logic [2:0] OP_FEATURE         = 3'd4;

    // Result kinds.
    localparam logic RESULT_STATE = 1'b0;
    localparam logic RESULT_LOGIT = 1'b1;

    localparam int ROW_CAP = 32;
    localparam int COL_CAP = 32;

    localparam logic signed [47:0] ACC_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] ACC_MIN = {1'b1, {47{1'b0}}};

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_UPD,
        ST_EMIT,
        ST_LOGIT,
        ST_LAST
    } seq_state_t;

    // Operation select for the shared unit.
    typedef enum logic [1:0] {
        MAC_ACC,
        MAC_UPD,
        MAC_LOGIT
    } mac_op_t;

    // Q16.16 product, floor shift by 16.
    function automatic logic signed [47:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        begin
            p = 64'(a) * 64'(b);
            qmul = p[63:16];
        end
    endfunction

    // Saturating 48-bit add.
    function automatic logic signed [47:0] sadd48(input logic signed [47:0] a,
                                                  input logic signed [47:0] b);
        logic signed [48:0] s;
        begin
            s = 49'(a) + 49'(b);
            if (s > 49'(ACC_MAX)) sadd48 = ACC_MAX;
            else if (s < 49'(ACC_MIN)) sadd48 = ACC_MIN;
            else sadd48 = s[47:0];
        end
    endfunction

    // Saturate a 48-bit value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        begin
            if (v > 48'sh00007FFFFFFF) sat32 = 32'sh7FFFFFFF;
            else if (v < -48'sh000080000000) sat32 = 32'sh80000000;
            else sat32 = v[31:0];
        end
    endfunction

endpackage

### hdl/ssmdr_ram.sv
`timescale 1ns / 1ps

module ssmdr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/ssmdr_mac.sv
`timescale 1ns / 1ps

module ssmdr_mac (
    input  logic                   clk,
    input  ssmdr_pkg::mac_op_t     op,
    input  logic signed [31:0]     a,
    input  logic signed [31:0]     b,
    input  logic signed [47:0]     addend,
    output logic signed [47:0]     sum,
    output logic signed [31:0]     sum32
);
    import ssmdr_pkg::*;

    logic signed [47:0] prod_reg;
    logic signed [47:0] addend_reg;
    mac_op_t            op_reg;
    logic signed [47:0] total;

    // Stage one: the multiply, registered.
    always_ff @(posedge clk)
    begin
        prod_reg   <= qmul(a, b);
        addend_reg <= addend;
        op_reg     <= op;
    end

    // Stage two: saturating 48-bit add; the state update takes the 32-bit clamp of it.
    always_comb
    begin
        total = sadd48(prod_reg, addend_reg);
        case (op_reg)
            MAC_UPD: sum = total;
            default: sum = total;
        endcase
        sum32 = sat32(total);
    end

endmodule

### hdl/ssm_diagonal_recurrence_step_top.sv
// Diagonal state-space step, signed Q16.16.
// Input channel: in_valid / in_stall with operation, row_index, feature_index,
// data_value and last_feature. A load beat writes the weight, decay, output
// weight or state store at the accepting edge, so loads follow one per cycle
// while the block is idle. A feature beat with an in-range feature_index runs
// the shared multiply-add unit once per active row, stepping each row through
// its read, operand and result phases; the next beat is taken once the block
// is back in idle. A beat marked last then updates each row and emits it on
// the output channel (out_valid / out_stall), global rows first, then slot
// rows, then the logit beat with last_result set, waiting on the receiver.
// The one multiply-add unit (two stages) and the single read port of each
// store pace the sequencer; the block takes no new beat until all results of
// the current one are delivered. A stalled output beat holds its payload; the
// sequencer waits on it. Reset clears the state vector, the accumulators
// (valid bits), the bias and the control. Weight and decay stores are
// undefined until written. The bias is written through cfg_we / cfg_data;
// the user must do so only while the block is idle, not enforced by the block.
module ssm_diagonal_recurrence_step_top #(
    parameter int NUM_FEATURES    = 32,
    parameter int NUM_GLOBAL_ROWS = 16,
    parameter int NUM_SLOT_ROWS   = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         operation,
    input  logic [4:0]         row_index,
    input  logic [4:0]         feature_index,
    input  logic signed [31:0] data_value,
    input  logic               last_feature,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               result_kind,
    output logic [4:0]         result_row,
    output logic signed [31:0] result_value,
    output logic               last_result
);
    import ssmdr_pkg::*;

    localparam int ROWS_SUM = NUM_GLOBAL_ROWS + NUM_SLOT_ROWS;
    localparam int ROWS = (ROWS_SUM < ROW_CAP) ? ROWS_SUM : ROW_CAP;
    localparam int COLS = (NUM_FEATURES < COL_CAP) ? NUM_FEATURES : COL_CAP;

    seq_state_t state_reg, state_next;
    logic [4:0] row_reg, row_next;
    logic [2:0] ph_reg, ph_next;
    logic [4:0] col_reg, col_next;
    logic signed [31:0] feat_reg, feat_next;
    logic last_reg, last_next;
    logic signed [31:0] bias_reg;
    logic signed [47:0] logit_reg, logit_next;
    logic [ROW_CAP-1:0] acc_ok_reg, acc_ok_next;
    logic [ROW_CAP-1:0] st_ok_reg, st_ok_next;
    logic signed [31:0] ns_reg, ns_next;
    logic out_valid_reg, out_valid_next;
    logic kind_reg, kind_next;
    logic [4:0] orow_reg, orow_next;
    logic signed [31:0] oval_reg, oval_next;

    logic accept;
    logic row_ok, col_ok;

    // Store ports.
    logic        w_we, d_we, o_we, s_we, a_we;
    logic [9:0]  w_waddr, w_raddr;
    logic [4:0]  s_waddr, a_waddr, rd_row;
    logic [31:0] s_wdata;
    logic [47:0] a_wdata;
    logic [31:0] w_rd, d_rd, o_rd, s_rd;
    logic [47:0] a_rd;

    // Shared unit ports.
    mac_op_t            m_op;
    logic signed [31:0] m_a, m_b;
    logic signed [47:0] m_add, m_sum;
    logic signed [31:0] m_sum32;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign row_ok   = (32'(row_index) < 32'(ROWS));
    assign col_ok   = (32'(feature_index) < 32'(COLS));

    assign w_we    = accept && operation == OP_LOAD_IN_WEIGHT && row_ok && col_ok;
    assign d_we    = accept && operation == OP_LOAD_DECAY && row_ok;
    assign o_we    = accept && operation == OP_LOAD_OUT_WEIGHT && row_ok;
    assign w_waddr = {row_index, feature_index};
    assign w_raddr = {rd_row, col_reg};

    ssmdr_ram #(.WIDTH(32), .DEPTH(1024)) u_wram (
        .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(data_value),
        .raddr(w_raddr), .rdata(w_rd));
    ssmdr_ram #(.WIDTH(32), .DEPTH(32)) u_dram (
        .clk(clk), .we(d_we), .waddr(row_index), .wdata(data_value),
        .raddr(rd_row), .rdata(d_rd));
    ssmdr_ram #(.WIDTH(32), .DEPTH(32)) u_oram (
        .clk(clk), .we(o_we), .waddr(row_index), .wdata(data_value),
        .raddr(rd_row), .rdata(o_rd));
    ssmdr_ram #(.WIDTH(32), .DEPTH(32)) u_sram (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(rd_row), .rdata(s_rd));
    ssmdr_ram #(.WIDTH(48), .DEPTH(32)) u_aram (
        .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
        .raddr(rd_row), .rdata(a_rd));

    ssmdr_mac u_mac (
        .clk(clk), .op(m_op), .a(m_a), .b(m_b), .addend(m_add),
        .sum(m_sum), .sum32(m_sum32));

    // Bias register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg <= '0;
        end
        else if (cfg_we)
        begin
            bias_reg <= cfg_data;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            ph_reg        <= '0;
            acc_ok_reg    <= '0;
            st_ok_reg     <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            ph_reg        <= ph_next;
            acc_ok_reg    <= acc_ok_next;
            st_ok_reg     <= st_ok_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        col_reg   <= col_next;
        feat_reg  <= feat_next;
        logit_reg <= logit_next;
        ns_reg    <= ns_next;
        kind_reg  <= kind_next;
        orow_reg  <= orow_next;
        oval_reg  <= oval_next;
    end

    // Sequencer. Each row: phase 0 read, 1 operands at unit, 2 result ready.
    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        ph_next        = ph_reg;
        col_next       = col_reg;
        feat_next      = feat_reg;
        last_next      = last_reg;
        logit_next     = logit_reg;
        acc_ok_next    = acc_ok_reg;
        st_ok_next     = st_ok_reg;
        ns_next        = ns_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        orow_next      = orow_reg;
        oval_next      = oval_reg;
        rd_row         = row_reg;
        s_we           = 1'b0;
        s_waddr        = row_index;
        s_wdata        = data_value;
        a_we           = 1'b0;
        a_waddr        = row_reg;
        a_wdata        = m_sum;
        m_op           = MAC_ACC;
        m_a            = w_rd;
        m_b            = feat_reg;
        m_add          = acc_ok_reg[row_reg] ? a_rd : '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    col_next  = feature_index;
                    feat_next = data_value;
                    last_next = last_feature;
                    row_next  = '0;
                    ph_next   = '0;
                    if (operation == OP_LOAD_STATE && row_ok)
                    begin
                        s_we = 1'b1;
                        st_ok_next[row_index] = 1'b1;
                    end
                    if (operation == OP_FEATURE)
                    begin
                        if (col_ok)
                            state_next = ST_MAC;
                        else if (last_feature)
                            state_next = ST_UPD;
                    end
                end
            end
            ST_MAC:
            begin
                ph_next = ph_reg + 3'd1;
                if (ph_reg == 3'd2)
                begin
                    a_we = 1'b1;
                    acc_ok_next[row_reg] = 1'b1;
                    ph_next = '0;
                    if (32'(row_reg) == 32'(ROWS - 1))
                    begin
                        row_next   = '0;
                        state_next = last_reg ? ST_UPD : ST_IDLE;
                    end
                    else
                    begin
                        row_next = row_reg + 5'd1;
                    end
                end
            end
            ST_UPD:
            begin
                // decay * state + accumulator, then wait for the output slot.
                m_op  = MAC_UPD;
                m_a   = d_rd;
                m_b   = st_ok_reg[row_reg] ? s_rd : '0;
                if (ph_reg != 3'd2)
                begin
                    ph_next = ph_reg + 3'd1;
                end
                else
                begin
                    ns_next = m_sum32;
                    ph_next = '0;
                    logit_next = (row_reg == '0) ? 48'(bias_reg) : logit_reg;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // Write back, emit, then run ns * output weight through the unit.
                m_op = MAC_LOGIT;
                m_a  = ns_reg;
                m_b  = o_rd;
                m_add = logit_reg;
                if (ph_reg == 3'd0)
                begin
                    if (!out_valid_next)
                    begin
                        s_we    = 1'b1;
                        s_waddr = row_reg;
                        s_wdata = ns_reg;
                        st_ok_next[row_reg] = 1'b1;
                        acc_ok_next[row_reg] = 1'b0;
                        out_valid_next = 1'b1;
                        kind_next = RESULT_STATE;
                        orow_next = row_reg;
                        oval_next = ns_reg;
                        ph_next   = 3'd1;
                    end
                end
                else if (ph_reg == 3'd1)
                begin
                    ph_next = 3'd2;
                end
                else
                begin
                    logit_next = m_sum;
                    ph_next    = '0;
                    if (32'(row_reg) == 32'(ROWS - 1))
                    begin
                        state_next = ST_LOGIT;
                    end
                    else
                    begin
                        row_next   = row_reg + 5'd1;
                        state_next = ST_UPD;
                    end
                end
            end
            ST_LOGIT:
            begin
                if (!out_valid_next)
                begin
                    out_valid_next = 1'b1;
                    kind_next  = RESULT_LOGIT;
                    orow_next  = '0;
                    oval_next  = sat32(logit_reg);
                    row_next   = '0;
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                if (!out_valid_next)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = kind_reg;
    assign result_row   = orow_reg;
    assign result_value = oval_reg;
    assign last_result  = kind_reg;

endmodule

### hdl/ssmdr_checker.sv
`timescale 1ns / 1ps
`include "ssm_diagonal_recurrence_step_top_assert.svh"

module ssmdr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        result_kind,
    input logic [4:0]  result_row,
    input logic [31:0] result_value,
    input logic        last_result
);

    // The logit beat carries the last mark and row zero.
    `SSM_ASSERT_IMPL(a_logit_last, out_valid, (last_result == result_kind), "last mark off")
    `SSM_ASSERT_IMPL(a_logit_row, out_valid && result_kind, (result_row == 5'd0), "logit row")
    // A stalled result beat holds.
    `SSM_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(result_value), "hold")
    // The block is busy while a result is still shown.
    `SSM_ASSERT_IMPL(a_busy, out_valid, in_stall, "input taken while results pending")

endmodule

bind ssm_diagonal_recurrence_step_top ssmdr_checker u_chk (.*);

### verif/ssm_diagonal_recurrence_step_top_tb.sv
`timescale 1ns / 1ps

module ssm_diagonal_recurrence_step_top_tb;
    import ssmdr_pkg::*;

    localparam int NROWS = 32;
    localparam int NCOLS = 32;
    localparam int SETTLE_CYCLES = 80;
    localparam logic [2:0] OP_RESERVED_LO = 3'd5;

    typedef struct packed {
        logic [2:0]         op;
        logic [4:0]         row;
        logic [4:0]         col;
        logic signed [31:0] data;
        logic               last;
    } in_beat_t;

    typedef struct packed {
        logic               kind;
        logic [4:0]         row;
        logic signed [31:0] value;
        logic               last;
    } out_beat_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         operation;
    logic [4:0]         row_index;
    logic [4:0]         feature_index;
    logic signed [31:0] data_value;
    logic               last_feature;
    logic               out_valid;
    logic               out_stall;
    logic               result_kind;
    logic [4:0]         result_row;
    logic signed [31:0] result_value;
    logic               last_result;

    ssm_diagonal_recurrence_step_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .row_index     (row_index),
        .feature_index (feature_index),
        .data_value    (data_value),
        .last_feature  (last_feature),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_kind   (result_kind),
        .result_row    (result_row),
        .result_value  (result_value),
        .last_result   (last_result)
    );

    // Stimulus and prediction bookkeeping.
    in_beat_t  beats_to_send[$];
    out_beat_t expected_results[$];
    int        send_idle_pct;
    int        stall_pct;
    int        errors;
    int        beats_sent;
    int        results_checked;
    int        steps_checked;
    bit        col_loaded[NCOLS];

    // Shadow copy of the block's stores.
    logic signed [31:0] in_weight[NROWS][NCOLS];
    logic signed [31:0] decay[NROWS];
    logic signed [31:0] out_weight[NROWS];
    logic signed [31:0] state_vec[NROWS];
    longint             row_acc[NROWS];
    logic signed [31:0] bias;

    // Clock.
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Q16.16 product with the low 16 bits dropped (floor).
    function automatic longint qprod(input longint a, input longint b);
        longint p;
        begin
            p = a * b;
            return p >>> 16;
        end
    endfunction

    function automatic longint clip48(input longint v);
        begin
            if (v > 64'sh00007FFFFFFFFFFF)
                return 64'sh00007FFFFFFFFFFF;
            if (v < -64'sh0000800000000000)
                return -64'sh0000800000000000;
            return v;
        end
    endfunction

    function automatic logic signed [31:0] clip32(input longint v);
        begin
            if (v > 64'sh7FFFFFFF)
                return 32'sh7FFFFFFF;
            if (v < -64'sh80000000)
                return 32'sh80000000;
            return v[31:0];
        end
    endfunction

    // Apply one accepted beat to the shadow stores and queue the step results.
    function automatic void advance_recurrence(input in_beat_t b);
        longint             logit;
        logic signed [31:0] ns;
        begin
            case (b.op)
                OP_LOAD_IN_WEIGHT:  in_weight[b.row][b.col] = b.data;
                OP_LOAD_DECAY:      decay[b.row] = b.data;
                OP_LOAD_OUT_WEIGHT: out_weight[b.row] = b.data;
                OP_LOAD_STATE:      state_vec[b.row] = b.data;
                OP_FEATURE:
                begin
                    for (int r = 0; r < NROWS; r++)
                        row_acc[r] = clip48(row_acc[r] + qprod(in_weight[r][b.col], b.data));
                    if (b.last)
                    begin
                        logit = bias;
                        for (int r = 0; r < NROWS; r++)
                        begin
                            ns = clip32(qprod(decay[r], state_vec[r]) + row_acc[r]);
                            state_vec[r] = ns;
                            row_acc[r] = 0;
                            logit = clip48(logit + qprod(ns, out_weight[r]));
                            expected_results.push_back({RESULT_STATE, 5'(r), ns, 1'b0});
                        end
                        expected_results.push_back({RESULT_LOGIT, 5'd0, clip32(logit), 1'b1});
                    end
                end
                default: ;
            endcase
        end
    endfunction

    // Input driver: holds a beat until it is taken, then fetches the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            operation     <= OP_FEATURE;
            row_index     <= '0;
            feature_index <= '0;
            data_value    <= '0;
            last_feature  <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                advance_recurrence({operation, row_index, feature_index, data_value,
                                    last_feature});
                beats_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (beats_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_beat_t nb;
                    nb = beats_to_send.pop_front();
                    in_valid      <= 1'b1;
                    operation     <= nb.op;
                    row_index     <= nb.row;
                    feature_index <= nb.col;
                    data_value    <= nb.data;
                    last_feature  <= nb.last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat kind=%0d row=%0d value=%0d",
                             $time, result_kind, result_row, result_value);
                    errors++;
                end
                else
                begin
                    out_beat_t e;
                    e = expected_results.pop_front();
                    if (e.kind !== result_kind)
                    begin
                        $display("%0t: result_kind expected %0d actual %0d",
                                 $time, e.kind, result_kind);
                        errors++;
                    end
                    if (e.row !== result_row)
                    begin
                        $display("%0t: result_row expected %0d actual %0d",
                                 $time, e.row, result_row);
                        errors++;
                    end
                    if (e.value !== result_value)
                    begin
                        $display("%0t: result_value expected %0d actual %0d",
                                 $time, e.value, result_value);
                        errors++;
                    end
                    if (e.last !== last_result)
                    begin
                        $display("%0t: last_result expected %0d actual %0d",
                                 $time, e.last, last_result);
                        errors++;
                    end
                    results_checked++;
                    if (e.last)
                        steps_checked++;
                end
            end
        end
    end

    // Small values half the time, with extremes and full-range values mixed in.
    function automatic logic signed [31:0] pick_value();
        begin
            case ($urandom_range(7))
                0: return 32'sh80000000;
                1: return 32'sh7FFFFFFF;
                2, 3: return $urandom;
                default: return $signed(32'($urandom_range(1 << 19))) - (1 << 18);
            endcase
        end
    endfunction

    function automatic logic [4:0] pick_loaded_col();
        logic [4:0] c;
        begin
            for (int t = 0; t < 64; t++)
            begin
                c = 5'($urandom_range(NCOLS - 1));
                if (col_loaded[c])
                    return c;
            end
            return 5'd0;
        end
    endfunction

    task automatic queue_beat(input logic [2:0] op, input logic [4:0] row,
                              input logic [4:0] col, input logic signed [31:0] data,
                              input logic last);
        begin
            beats_to_send.push_back({op, row, col, data, last});
            if (op == OP_LOAD_IN_WEIGHT)
                col_loaded[col] = 1'b1;
        end
    endtask

    // Load a whole column of input weights so feature beats may use it.
    task automatic queue_column(input logic [4:0] col);
        begin
            for (int r = 0; r < NROWS; r++)
                queue_beat(OP_LOAD_IN_WEIGHT, 5'(r), col, pick_value(),
                           1'($urandom_range(1)));
        end
    endtask

    // Wait until every beat is taken, every result is back, and the block has settled.
    task automatic drain();
        begin
            while (beats_to_send.size() > 0 || in_valid || expected_results.size() > 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_bias(input logic signed [31:0] v);
        begin
            @(posedge clk);
            cfg_we   <= 1'b1;
            cfg_data <= v;
            bias = v;
            @(posedge clk);
            cfg_we   <= 1'b0;
        end
    endtask

    // Random traffic: mostly full steps, with loads and ignored beats between them.
    task automatic queue_random(input int count);
        int n;
        int done;
        begin
            done = 0;
            while (done < count)
            begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5:
                    begin
                        n = $urandom_range(1, 5);
                        for (int k = 0; k < n; k++)
                            queue_beat(OP_FEATURE, 5'($urandom), pick_loaded_col(),
                                       pick_value(), k == n - 1);
                        done += n;
                    end
                    6, 7:
                    begin
                        if ($urandom_range(5) == 0)
                        begin
                            queue_column(5'($urandom));
                            done += NROWS;
                        end
                        else
                        begin
                            queue_beat(OP_LOAD_IN_WEIGHT, 5'($urandom), pick_loaded_col(),
                                       pick_value(), 1'($urandom_range(1)));
                            done++;
                        end
                    end
                    8:
                    begin
                        queue_beat(OP_LOAD_DECAY + 3'($urandom_range(2)), 5'($urandom),
                                   5'($urandom), pick_value(), 1'($urandom_range(1)));
                        done++;
                    end
                    default:
                    begin
                        queue_beat(OP_RESERVED_LO + 3'($urandom_range(2)), 5'($urandom),
                                   5'($urandom), $urandom, 1'($urandom_range(1)));
                        done++;
                    end
                endcase
            end
        end
    endtask

    // Main sequence.
    initial
    begin
        logic signed [31:0] phase_bias[4];
        int idle_in[4];
        int idle_out[4];

        phase_bias = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh0, 32'sh00010000};
        idle_in    = '{0, 62, 0, 33};
        idle_out   = '{0, 0, 62, 33};

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        errors = 0;
        beats_sent = 0;
        results_checked = 0;
        steps_checked = 0;
        bias = '0;
        for (int r = 0; r < NROWS; r++)
        begin
            state_vec[r] = '0;
            row_acc[r] = 0;
            decay[r] = '0;
            out_weight[r] = '0;
            for (int c = 0; c < NCOLS; c++)
                in_weight[r][c] = '0;
        end
        for (int c = 0; c < NCOLS; c++)
            col_loaded[c] = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Fill every decay and output weight, plus input weight columns 0 and 31.
        for (int r = 0; r < NROWS; r++)
        begin
            queue_beat(OP_LOAD_DECAY, 5'(r), 5'($urandom), pick_value(),
                       1'($urandom_range(1)));
            queue_beat(OP_LOAD_OUT_WEIGHT, 5'(r), 5'($urandom), pick_value(),
                       1'($urandom_range(1)));
        end
        queue_column(5'd0);
        queue_column(5'd31);

        // Directed: extreme features and states, reserved operations, ignored last marks.
        queue_beat(OP_FEATURE, 5'd0, 5'd31, 32'sh7FFFFFFF, 1'b0);
        queue_beat(OP_FEATURE, 5'd31, 5'd0, 32'sh80000000, 1'b1);
        queue_beat(OP_LOAD_STATE, 5'd0, 5'd31, 32'sh7FFFFFFF, 1'b1);
        queue_beat(OP_LOAD_STATE, 5'd31, 5'd0, 32'sh80000000, 1'b0);
        queue_beat(OP_LOAD_DECAY, 5'd0, 5'd31, 32'sh7FFFFFFF, 1'b1);
        queue_beat(OP_RESERVED_LO, 5'd3, 5'd0, 32'sh7FFFFFFF, 1'b1);
        queue_beat(OP_RESERVED_LO + 3'd1, 5'd31, 5'd31, 32'sh80000000, 1'b1);
        queue_beat(OP_RESERVED_LO + 3'd2, 5'd0, 5'd31, 32'sh0, 1'b0);
        queue_beat(OP_FEATURE, 5'd7, 5'd31, 32'sh80000000, 1'b0);
        queue_beat(OP_FEATURE, 5'd7, 5'd31, 32'sh80000000, 1'b0);
        queue_beat(OP_FEATURE, 5'd0, 5'd0, 32'sh7FFFFFFF, 1'b1);
        queue_beat(OP_LOAD_OUT_WEIGHT, 5'd31, 5'd31, 32'sh80000000, 1'b0);
        queue_beat(OP_FEATURE, 5'd0, 5'd0, 32'sh0, 1'b1);
        queue_beat(OP_FEATURE, 5'd31, 5'd31, 32'sh00010000, 1'b1);

        // Each phase changes the bias and the idling pattern.
        for (int p = 0; p < 4; p++)
        begin
            drain();
            write_bias(phase_bias[p]);
            send_idle_pct = idle_in[p];
            stall_pct = idle_out[p];
            queue_random(38);
        end
        drain();
        write_bias($urandom);
        send_idle_pct = 0;
        stall_pct = 0;
        queue_beat(OP_FEATURE, 5'($urandom), pick_loaded_col(), pick_value(), 1'b1);
        drain();

        $display("Sent %0d input beats and checked %0d result beats over %0d steps,",
                 beats_sent, results_checked, steps_checked);
        $display("across five bias settings and four idle and stall patterns.");
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #1500000;
        $display("Timed out with %0d results outstanding.", expected_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/ssmdr_pkg.sv
hdl/ssmdr_ram.sv
hdl/ssmdr_mac.sv
hdl/ssm_diagonal_recurrence_step_top.sv
hdl/ssmdr_checker.sv
verif/ssm_diagonal_recurrence_step_top_tb.sv
